/* design/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg
// Types and constants shared by the accelerometer fall detector.
// ----------------------------------------------------------------------------
package afd_pkg;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_word_type;

   typedef struct packed {
      logic [15:0] total_magnitude;
      logic [15:0] horizontal_magnitude;
      logic [15:0] window_value;
      logic        window_done;
      logic [1:0]  event_code;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_JUDGE,
      ST_SCALE,
      ST_CLOSE,
      ST_FINISH
   } fsm_state_type;

   localparam logic [1:0] EVENT_NONE   = 2'd0;
   localparam logic [1:0] EVENT_IMPACT = 2'd1;
   localparam logic [1:0] EVENT_WINDOW = 2'd2;

   localparam logic [1:0] REG_IMPACT_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WINDOW_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_INTEGRAL_GAIN    = 2'd2;
   localparam logic [1:0] REG_WINDOW_LENGTH    = 2'd3;

   localparam logic [15:0] IMPACT_THRESHOLD_RESET = 16'd12288;
   localparam logic [15:0] WINDOW_THRESHOLD_RESET = 16'd4096;
   localparam logic [15:0] INTEGRAL_GAIN_RESET    = 16'd521;
   localparam logic [7:0]  WINDOW_LENGTH_RESET    = 8'd94;

   localparam int STEP_COUNT = 16;
   localparam logic [3:0] LAST_STEP = 4'(STEP_COUNT - 1);

endpackage

/* design/accel_fall_detector_top.sv */
// ----------------------------------------------------------------------------
// accel_fall_detector_top
// Fall detector for three-axis accelerometer samples.
//
// Each word on the req_ channel is one raw sample. The rsp_ channel returns
// one word per sample: total and horizontal magnitude, the scaled window sum
// when the sample closes a window, and an event code. Squares, products and
// square roots are computed serially: the squares and the window gain product
// take one multiplier bit per cycle, the roots two radicand bits per cycle.
// A sample that closes an integration window also runs the gain product.
// No new sample is taken while one is in work; the next is accepted in the
// cycle after the response is registered. A finished response waits in the
// output register while the next sample is taken in; when the receiver
// stalls for longer than a sample takes, the block holds the next result and
// stalls its input. Reset is synchronous; it empties the output register,
// restores the default register values and starts a new window. Registers
// are written through the csr_ port at byte addresses 0, 4, 8 and 12, by the
// user only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module accel_fall_detector_top
   import afd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   fsm_state_type state_ff, state_in;
   logic [3:0]    step_ff, step_in;

   logic [15:0] impact_thr_ff, impact_thr_in;
   logic [15:0] window_thr_ff, window_thr_in;
   logic [15:0] gain_ff, gain_in;
   logic [7:0]  length_ff, length_in;

   logic [7:0]  index_ff, index_in;
   logic [24:0] wsum_ff, wsum_in;

   logic [15:0] mag_ff [3];
   logic [15:0] mag_in [3];
   logic [31:0] sq_ff [3];
   logic [31:0] sq_in [3];

   logic [31:0] nt_ff, nt_in, nh_ff, nh_in;
   logic [16:0] rem_t_ff, rem_t_in, rem_h_ff, rem_h_in;
   logic [15:0] root_t_ff, root_t_in, root_h_ff, root_h_in;

   logic [40:0] prod_ff, prod_in;

   rsp_word_type res_ff, res_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic        req_accept;
   logic        slot_free;
   logic        csr_write;
   logic [15:0] abs_val [3];
   logic [16:0] sq_sum [3];
   logic [25:0] prod_sum;
   logic [32:0] step_t, step_h;
   logic [24:0] wsum_term, wsum_new;
   logic [8:0]  count;
   logic [15:0] scaled_sat;

   function automatic logic [32:0] sqrt_step(input logic [16:0] rem,
                                             input logic [15:0] root,
                                             input logic [1:0]  digit);
      logic [18:0] rem_shift;
      logic [18:0] trial;
      logic [18:0] diff;
      rem_shift = {rem, digit};
      trial     = {1'b0, root, 2'b01};
      diff      = rem_shift - trial;
      if (rem_shift >= trial) begin
         sqrt_step = {diff[16:0], root[14:0], 1'b1};
      end else begin
         sqrt_step = {rem_shift[16:0], root[14:0], 1'b0};
      end
   endfunction

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   assign abs_val[0] = req_data.accel_x[15] ? (~req_data.accel_x + 16'd1) : req_data.accel_x;
   assign abs_val[1] = req_data.accel_y[15] ? (~req_data.accel_y + 16'd1) : req_data.accel_y;
   assign abs_val[2] = req_data.accel_z[15] ? (~req_data.accel_z + 16'd1) : req_data.accel_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_sum[i] = {1'b0, sq_ff[i][31:16]} + (sq_ff[i][0] ? {1'b0, mag_ff[i]} : 17'd0);
      end
   end

   assign prod_sum   = {1'b0, prod_ff[40:16]} + (prod_ff[0] ? {1'b0, wsum_ff} : 26'd0);
   assign step_t     = sqrt_step(rem_t_ff, root_t_ff, nt_ff[31:30]);
   assign step_h     = sqrt_step(rem_h_ff, root_h_ff, nh_ff[31:30]);
   assign wsum_term  = (index_ff == 8'd0) ? {9'd0, root_h_ff} : {8'd0, root_h_ff, 1'b0};
   assign wsum_new   = wsum_ff + wsum_term;
   assign count      = {1'b0, index_ff} + 9'd1;
   assign scaled_sat = (|prod_ff[40:32]) ? 16'hFFFF : prod_ff[31:16];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (step_ff == LAST_STEP) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == LAST_STEP) state_in = ST_JUDGE;
         end
         ST_JUDGE: begin
            if (root_t_ff >= impact_thr_ff) begin
               state_in = ST_FINISH;
            end else if (count >= {1'b0, length_ff}) begin
               state_in = ST_SCALE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCALE: begin
            if (step_ff == LAST_STEP) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      index_in     = index_ff;
      wsum_in      = wsum_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      nt_in        = nt_ff;
      nh_in        = nh_ff;
      rem_t_in     = rem_t_ff;
      rem_h_in     = rem_h_ff;
      root_t_in    = root_t_ff;
      root_h_in    = root_h_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            step_in = 4'd0;
            if (req_accept) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = abs_val[i];
                  sq_in[i]  = {16'd0, abs_val[i]};
               end
            end
         end
         ST_SQUARE: begin
            step_in = step_ff + 4'd1;
            for (int i = 0; i < 3; i++) begin
               sq_in[i] = {sq_sum[i], sq_ff[i][15:1]};
            end
         end
         ST_SUM: begin
            step_in   = 4'd0;
            nh_in     = sq_ff[0] + sq_ff[2];
            nt_in     = sq_ff[0] + sq_ff[1] + sq_ff[2];
            rem_t_in  = 17'd0;
            rem_h_in  = 17'd0;
            root_t_in = 16'd0;
            root_h_in = 16'd0;
         end
         ST_ROOT: begin
            step_in   = step_ff + 4'd1;
            nt_in     = {nt_ff[29:0], 2'b00};
            nh_in     = {nh_ff[29:0], 2'b00};
            rem_t_in  = step_t[32:16];
            root_t_in = step_t[15:0];
            rem_h_in  = step_h[32:16];
            root_h_in = step_h[15:0];
         end
         ST_JUDGE: begin
            step_in                     = 4'd0;
            res_in.total_magnitude      = root_t_ff;
            res_in.horizontal_magnitude = root_h_ff;
            res_in.window_value         = 16'd0;
            res_in.window_done          = 1'b0;
            res_in.event_code           = EVENT_NONE;
            if (root_t_ff >= impact_thr_ff) begin
               res_in.event_code = EVENT_IMPACT;
               index_in          = 8'd0;
               wsum_in           = 25'd0;
            end else begin
               wsum_in = wsum_new;
               if (count >= {1'b0, length_ff}) begin
                  prod_in    = {25'd0, gain_ff};
               end else begin
                  index_in = count[7:0];
               end
            end
         end
         ST_SCALE: begin
            step_in = step_ff + 4'd1;
            prod_in = {prod_sum, prod_ff[15:1]};
         end
         ST_CLOSE: begin
            res_in.window_value = scaled_sat;
            res_in.window_done  = 1'b1;
            res_in.event_code   = (scaled_sat >= window_thr_ff) ? EVENT_WINDOW : EVENT_NONE;
            index_in            = 8'd0;
            wsum_in             = 25'd0;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            step_in = 4'd0;
         end
      endcase
   end

   always_comb begin
      impact_thr_in = impact_thr_ff;
      window_thr_in = window_thr_ff;
      gain_in       = gain_ff;
      length_in     = length_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_IMPACT_THRESHOLD: impact_thr_in = csr_pwdata[15:0];
            REG_WINDOW_THRESHOLD: window_thr_in = csr_pwdata[15:0];
            REG_INTEGRAL_GAIN:    gain_in       = csr_pwdata[15:0];
            REG_WINDOW_LENGTH:    length_in     = csr_pwdata[7:0];
            default: begin
               impact_thr_in = impact_thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_IMPACT_THRESHOLD: csr_prdata = {16'd0, impact_thr_ff};
         REG_WINDOW_THRESHOLD: csr_prdata = {16'd0, window_thr_ff};
         REG_INTEGRAL_GAIN:    csr_prdata = {16'd0, gain_ff};
         REG_WINDOW_LENGTH:    csr_prdata = {24'd0, length_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= 4'd0;
         index_ff      <= 8'd0;
         wsum_ff       <= 25'd0;
         rsp_valid_ff  <= 1'b0;
         impact_thr_ff <= IMPACT_THRESHOLD_RESET;
         window_thr_ff <= WINDOW_THRESHOLD_RESET;
         gain_ff       <= INTEGRAL_GAIN_RESET;
         length_ff     <= WINDOW_LENGTH_RESET;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         index_ff      <= index_in;
         wsum_ff       <= wsum_in;
         rsp_valid_ff  <= rsp_valid_in;
         impact_thr_ff <= impact_thr_in;
         window_thr_ff <= window_thr_in;
         gain_ff       <= gain_in;
         length_ff     <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      sq_ff       <= sq_in;
      nt_ff       <= nt_in;
      nh_ff       <= nh_in;
      rem_t_ff    <= rem_t_in;
      rem_h_ff    <= rem_h_in;
      root_t_ff   <= root_t_in;
      root_h_ff   <= root_h_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;

endmodule
